/* hw/rtl/rpd_pkg.sv */
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the packet-message deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int HDR_BYTES = 44;
  localparam int TYPE_LANE_END = 4;
  localparam int OFFSET_LANE_START = 8;
  localparam int OFFSET_LANE_END = 12;
  localparam int LENGTH_LANE_END = 16;

  localparam logic [31:0] TYPE_PACKET = 32'h0000_0001;
  localparam logic [31:0] TYPE_KEEPALIVE = 32'h0000_0008;
  localparam logic [31:0] PAYLOAD_BIAS = 32'h0000_0008;

  localparam logic [14:0] MAX_FRAME_RESET = 15'd1514;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [31:0] reply_request_id;
  } rpd_result_t;

endpackage

/* hw/rtl/rpd_parse.sv */
// ----------------------------------------------------------------------------
// rpd_parse
// Header capture, transfer tracking and per-byte forwarding decision.
// ----------------------------------------------------------------------------
module rpd_parse import rpd_pkg::*; #(
  parameter int XFER_CAP = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        first_of_transfer,
  input  logic [14:0] transfer_length,
  input  logic [14:0] max_frame_length,
  output rpd_result_t result
);

  localparam int LW = $clog2(XFER_CAP + 1);
  localparam int TW = (LW > 15) ? LW : 15;

  logic [LW-1:0] pos, pos_next;
  logic [LW-1:0] held, held_next;
  logic          discard, discard_next;
  logic [31:0]   msg_code, msg_code_next;
  logic [31:0]   offset, offset_next;
  logic [31:0]   length, length_next;
  logic [33:0]   start, start_next;
  logic          pkt_ok, pkt_ok_next;

  logic [TW-1:0] tlen_ext;
  logic [LW-1:0] held_first;
  logic [LW-1:0] eff_pos;
  logic [LW-1:0] pos_inc;
  logic          eff_disc;
  logic          live;
  logic [TW-1:0] rel_w, len_w, mfl_w;
  logic          in_frame, last, keep;

  always_comb begin
    tlen_ext   = TW'(transfer_length);
    held_first = (tlen_ext > TW'(XFER_CAP)) ? LW'(XFER_CAP) : LW'(tlen_ext);

    eff_pos  = first_of_transfer ? '0 : pos;
    eff_disc = first_of_transfer ? (held_first < LW'(HDR_BYTES)) : discard;
    live     = !eff_disc;
    pos_inc  = eff_pos + LW'(1);

    held_next     = first_of_transfer ? held_first : held;
    msg_code_next = first_of_transfer ? '0 : msg_code;
    offset_next   = first_of_transfer ? '0 : offset;
    length_next   = first_of_transfer ? '0 : length;
    pkt_ok_next   = first_of_transfer ? 1'b0 : pkt_ok;
    start_next    = start;
    pos_next      = eff_pos;
    discard_next  = eff_disc;

    if (live) begin
      if (eff_pos < LW'(TYPE_LANE_END))
        msg_code_next[8*eff_pos[1:0] +: 8] = data_byte;
      else if (eff_pos >= LW'(OFFSET_LANE_START) && eff_pos < LW'(OFFSET_LANE_END))
        offset_next[8*eff_pos[1:0] +: 8] = data_byte;
      else if (eff_pos >= LW'(OFFSET_LANE_END) && eff_pos < LW'(LENGTH_LANE_END))
        length_next[8*eff_pos[1:0] +: 8] = data_byte;

      // data start one byte ahead, bound check on the last header byte
      if (eff_pos == LW'(HDR_BYTES - 2))
        start_next = {2'b00, offset} + {2'b00, PAYLOAD_BIAS};
      if (eff_pos == LW'(HDR_BYTES - 1))
        pkt_ok_next = (msg_code == TYPE_PACKET) && (start >= 34'(HDR_BYTES)) &&
                      ((start + {2'b00, length}) <= 34'(held));

      pos_next     = pos_inc;
      discard_next = (pos_inc >= held_next);
    end

    keep  = (eff_pos == LW'(HDR_BYTES - 1)) && (msg_code == TYPE_KEEPALIVE);
    rel_w = TW'(eff_pos - start[LW-1:0]);
    len_w = TW'(length[LW-1:0]);
    mfl_w = TW'(max_frame_length);
    in_frame = pkt_ok && (eff_pos >= LW'(HDR_BYTES)) && (eff_pos >= start[LW-1:0]) &&
               (rel_w < len_w) && (rel_w < mfl_w);
    last = ((rel_w + TW'(1) == len_w) && (rel_w < mfl_w)) ||
           ((rel_w + TW'(1) == mfl_w) && (rel_w < len_w));

    result = '0;
    if (accept && live) begin
      if (keep) begin
        result.valid            = 1'b1;
        result.kind             = KIND_REPLY;
        result.reply_request_id = offset;
      end else if (in_frame) begin
        result.valid         = 1'b1;
        result.kind          = KIND_FRAME;
        result.payload_byte  = data_byte;
        result.last_of_frame = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      held    <= '0;
      discard <= 1'b1;
      pkt_ok  <= 1'b0;
    end else if (accept) begin
      pos     <= pos_next;
      held    <= held_next;
      discard <= discard_next;
      pkt_ok  <= pkt_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg_code <= msg_code_next;
      offset   <= offset_next;
      length   <= length_next;
      start    <= start_next;
    end
  end

endmodule

/* hw/rtl/rndis_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// rndis_packet_deframer_top
// Packet-message deframer for a received bulk transfer byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one transfer byte per request;
// first_of_transfer marks the first byte and transfer_length is sampled then.
// Output channel (out_valid/out_ready) gives either an ethernet frame byte
// (kind 0, with last_of_frame on the final byte) or a keepalive reply request
// (kind 1, with reply_request_id), at most one per input byte.
// A result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless out_ready stalls; the parse state and
// forwarding decision are evaluated on accept and land in the output register.
// in_ready follows the output register: a new byte is taken while the output
// register is empty or its held result is being taken in the same cycle, so a
// stalled receiver stops the input after one held result.
// cfg_write loads max_frame_length (cfg_data); write it between transfers.
// Reset: output empty, no transfer in progress (bytes ignored until a
// marked first byte), max_frame_length back to 1514.
// ----------------------------------------------------------------------------
module rndis_packet_deframer_top import rpd_pkg::*; #(
  parameter int XFER_CAP = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_of_transfer,
  input  logic [14:0] transfer_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic        last_of_frame,
  output logic [31:0] reply_request_id,
  input  logic        cfg_write,
  input  logic [14:0] cfg_data
);

  logic [14:0] max_frame_length;
  logic        accept;
  rpd_result_t result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_RESET;
    end else if (cfg_write) begin
      max_frame_length <= cfg_data;
    end
  end

  rpd_parse #(
    .XFER_CAP(XFER_CAP)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (data_byte),
    .first_of_transfer(first_of_transfer),
    .transfer_length  (transfer_length),
    .max_frame_length (max_frame_length),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      kind             <= result.kind;
      payload_byte     <= result.payload_byte;
      last_of_frame    <= result.last_of_frame;
      reply_request_id <= result.reply_request_id;
    end
  end

  a_reply_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REPLY) |-> (payload_byte == 8'h00) && !last_of_frame)
    else $error("reply request carries frame data");

  a_frame_no_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FRAME) |-> (reply_request_id == 32'h0))
    else $error("frame byte carries a request id");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
